[sv/ssu_pkg.sv]
// Shared types and constants for the shared unique symbol score unit.
// Used by the top level and ssu_mac; depends on nothing.
package ssu_pkg;

  // Sizing of the symbol table and the sequence numbering
  localparam int SYMBOLS       = 4096;
  localparam int MAX_SEQUENCES = 1024;

  // Fixed field widths
  localparam int OP_W    = 2;
  localparam int SYM_W   = 12;
  localparam int ALPHA_W = 13;
  localparam int SCORE_W = 32;

  // Derived widths
  localparam int ADDR_W  = $clog2(SYMBOLS);
  localparam int CODE_W  = ($clog2(SYMBOLS + 1) > ALPHA_W) ? $clog2(SYMBOLS + 1) : ALPHA_W;
  localparam int CUR_W   = $clog2(MAX_SEQUENCES + 1);
  localparam int LAST_W  = CUR_W;
  localparam int CNT_W   = $clog2(MAX_SEQUENCES + 1);
  localparam int PROD_W  = 2 * CNT_W;
  localparam int SUM_W   = ((PROD_W > SCORE_W) ? PROD_W : SCORE_W) + 1;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(4096);

  // Operation codes
  localparam logic [OP_W-1:0] OP_SYMBOL = 2'd0;
  localparam logic [OP_W-1:0] OP_END    = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  // Input and result words
  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [SYM_W-1:0] symbol;
  } in_word_t;

  typedef struct packed {
    logic [SCORE_W-1:0] total_score;
    logic               overflow;
  } out_word_t;

  // One symbol table entry
  typedef struct packed {
    logic              repeated;
    logic [CNT_W-1:0]  count;
    logic [LAST_W-1:0] last_seq;
  } entry_t;

  // Never-seen marker: all ones lies above every usable sequence number
  localparam logic [LAST_W-1:0] NEVER_SEEN = '1;
  localparam entry_t ENTRY_CLEAR = '{repeated: 1'b0, count: '0, last_seq: NEVER_SEEN};

  // Control of the multiply-accumulate unit
  typedef struct packed {
    logic             clear;
    logic             en;
    logic [CNT_W-1:0] count;
  } mac_ctl_t;

endpackage

[sv/shared_unique_symbol_score_unit.sv]
// Top level of the shared unique symbol score unit: sequencer, symbol table, MAC.
// Depends on ssu_pkg, ssu_ram and ssu_mac.
//
// Usage:
//   Input words (operation, symbol) are taken when start is high and busy low.
//   A symbol word takes one table read, then one write back.
//   An end-of-sequence word touches only the sequence number.
//   A finish word sweeps every table entry through the one RAM read port,
//   one entry a cycle, clearing each entry behind the read; the score result
//   is driven once the last entry has passed the read, multiply and add
//   stages, and the next word can be taken as soon as the result is driven.
//   The result word is on out_word for exactly one cycle with out_valid high;
//   the receiver cannot stall it. busy stays high throughout each symbol and finish operation.
//   After reset the table is cleared by a pass over all SYMBOLS entries
//   during which busy is high; cfg writes are taken at any time (cfg_ready is
//   always high) and should only be made while the block is idle.
//   The alphabet size register resets to 4096.
module shared_unique_symbol_score_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  ssu_pkg::in_word_t             in_word,
  output logic                          out_valid,
  output ssu_pkg::out_word_t            out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssu_pkg::ALPHA_W-1:0]   cfg_data
);
  import ssu_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(SYMBOLS - 1);
  localparam logic [CUR_W-1:0]  MAX_SEQ  = CUR_W'(MAX_SEQUENCES);
  localparam logic [LAST_W-1:0] TOP_SEQ  = LAST_W'(MAX_SEQUENCES - 1);

  logic [2:0]         state_r, state_nxt;
  logic [ALPHA_W-1:0] alpha_r;
  logic [CUR_W-1:0]   cur_seq_r;
  logic               ovf_r;
  logic [ADDR_W-1:0]  idx_r;
  logic [ADDR_W-1:0]  rd_idx_r;
  logic               rd_vld_r;
  logic [1:0]         drain_r;
  logic [ADDR_W-1:0]  sym_r;
  logic [LAST_W-1:0]  seq_r;
  logic               hit_r;
  logic               out_valid_r;
  out_word_t          out_word_r;

  logic               accept;
  logic [CODE_W-1:0]  counted;
  logic [CODE_W-1:0]  in_code;
  logic [LAST_W-1:0]  seq_eff;
  logic               seq_over;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  entry_t             wr_data;
  logic [ADDR_W-1:0]  rd_addr;
  entry_t             rd_data;
  logic [$bits(entry_t)-1:0] rd_bits;

  mac_ctl_t           mac_ctl;
  logic [SCORE_W-1:0] mac_sum;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // codes counted: alphabet size capped at the table depth
  assign counted = (CODE_W'(alpha_r) > CODE_W'(SYMBOLS)) ? CODE_W'(SYMBOLS) : CODE_W'(alpha_r);
  assign in_code = CODE_W'(in_word.symbol);

  // sequence number a symbol is filed under; past the limit, the last one
  assign seq_over = (cur_seq_r >= MAX_SEQ);
  assign seq_eff  = seq_over ? TOP_SEQ : LAST_W'(cur_seq_r);

  // table read address: sweep index while sweeping, incoming symbol otherwise
  assign rd_addr = (state_r == S_SWEEP) ? idx_r : in_code[ADDR_W-1:0];

  // table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = ENTRY_CLEAR;
    if (state_r == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (rd_vld_r) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_r;
    end else if (state_r == S_UPD) begin
      wr_addr = sym_r;
      wr_data = rd_data;
      if (hit_r && !rd_data.repeated) begin
        wr_en = 1'b1;
        if (rd_data.last_seq == seq_r) begin
          wr_data.repeated = 1'b1;
        end else begin
          wr_data.last_seq = seq_r;
          wr_data.count    = rd_data.count + CNT_W'(1);
        end
      end
    end
  end

  ssu_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SYMBOLS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );
  assign rd_data = entry_t'(rd_bits);

  // MAC feed: unflagged entries below the counted alphabet
  assign mac_ctl.clear = accept && (in_word.operation == OP_FINISH);
  assign mac_ctl.en    = rd_vld_r && !rd_data.repeated && (CODE_W'(rd_idx_r) < counted);
  assign mac_ctl.count = rd_data.count;

  ssu_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .sum   (mac_sum)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (idx_r == LAST_IDX) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (in_word.operation)
            OP_SYMBOL: state_nxt = S_UPD;
            OP_FINISH: state_nxt = S_SWEEP;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_UPD:   state_nxt = S_IDLE;
      S_SWEEP: if (idx_r == LAST_IDX) state_nxt = S_DRAIN;
      S_DRAIN: if (drain_r == 2'd2) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      alpha_r     <= ALPHA_RESET;
      cur_seq_r   <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= (state_r == S_SWEEP);
      rd_idx_r    <= idx_r;
      out_valid_r <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        alpha_r <= cfg_data;
      end

      unique case (state_r)
        S_CLEAR: idx_r <= idx_r + ADDR_W'(1);
        S_IDLE: begin
          if (accept) begin
            unique case (in_word.operation)
              OP_SYMBOL: begin
                sym_r <= in_code[ADDR_W-1:0];
                seq_r <= seq_eff;
                hit_r <= (in_code < counted);
                if (seq_over) ovf_r <= 1'b1;
              end
              OP_END: begin
                if (!seq_over) cur_seq_r <= cur_seq_r + CUR_W'(1);
              end
              OP_FINISH: idx_r <= '0;
              default: ;
            endcase
          end
        end
        S_UPD: ;
        S_SWEEP: begin
          idx_r   <= idx_r + ADDR_W'(1);
          drain_r <= '0;
        end
        S_DRAIN: begin
          drain_r <= drain_r + 2'd1;
          if (drain_r == 2'd2) begin
            out_valid_r            <= 1'b1;
            out_word_r.total_score <= mac_sum;
            out_word_r.overflow    <= ovf_r;
            cur_seq_r              <= '0;
            ovf_r                  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // a symbol word keeps the block busy for its write-back cycle
  a_symbol_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_word.operation == OP_SYMBOL)) |=> busy)
    else $error("symbol word did not occupy the write-back cycle");

  // reset starts the table clearing pass
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("block not busy after reset");

  // results come only out of the drain of a sweep
  a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_DRAIN))
    else $error("result emitted outside a finish sweep");

endmodule

[sv/ssu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module ssu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/ssu_mac.sv]
// Multiply-accumulate unit for the score sweep: count*(count-1), saturating sum.
// Depends on ssu_pkg.
module ssu_mac (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ssu_pkg::mac_ctl_t         ctl,
  output logic [ssu_pkg::SCORE_W-1:0] sum
);
  import ssu_pkg::*;

  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  prod_nxt;
  logic [SCORE_W-1:0] acc_r;
  logic [SUM_W-1:0]   acc_sum;
  logic [CNT_W-1:0]   cnt_m1;

  // product stage; an empty or skipped entry contributes zero
  assign cnt_m1   = ctl.count - CNT_W'(1);
  assign prod_nxt = (ctl.en && (ctl.count != '0)) ?
                    PROD_W'(PROD_W'(ctl.count) * PROD_W'(cnt_m1)) : '0;

  // accumulate stage with saturation at all ones
  assign acc_sum = SUM_W'(acc_r) + SUM_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= '0;
      acc_r  <= '0;
    end else begin
      prod_r <= prod_nxt;
      if (ctl.clear) begin
        acc_r <= '0;
      end else if (acc_sum > SUM_W'({SCORE_W{1'b1}})) begin
        acc_r <= '1;
      end else begin
        acc_r <= acc_sum[SCORE_W-1:0];
      end
    end
  end

  assign sum = acc_r;

endmodule
